// File: rtl/twiss_from_one_turn_matrix_macros.svh
// Assertion helpers for the Twiss block.
`ifndef TWISS_FROM_ONE_TURN_MATRIX_MACROS_SVH
`define TWISS_FROM_ONE_TURN_MATRIX_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TWF_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("twf: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TWF_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("twf: next-cycle check failed");

`endif

// File: rtl/twf_pkg.sv
`default_nettype none
package twf_pkg;

  localparam int SqrtSteps   = 31;
  localparam int DivSteps    = 32;
  localparam int CordicSteps = 30;

  localparam logic [1:0] TWF_ST_OK       = 2'd0;
  localparam logic [1:0] TWF_ST_UNSTABLE = 2'd1;
  localparam logic [1:0] TWF_ST_ZERO_DIV = 2'd2;

  localparam logic [23:0] ScaleReset = 24'd500000;
  localparam logic [31:0] LimPos     = 32'h7FFF_FFFF;
  localparam logic [31:0] LimNeg     = 32'h8000_0000;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;

  typedef struct packed {
    logic signed [47:0] pos_plus_x;
    logic signed [47:0] ang_plus_x;
    logic signed [47:0] pos_minus_x;
    logic signed [47:0] ang_minus_x;
    logic signed [47:0] pos_plus_xp;
    logic signed [47:0] ang_plus_xp;
    logic signed [47:0] pos_minus_xp;
    logic signed [47:0] ang_minus_xp;
  } twf_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] beta_value;
    logic signed [31:0] alpha_value;
    logic signed [31:0] gamma_value;
    logic [31:0]        tune_fraction;
  } twf_out_t;

  // Item in the square-root chain, with the sideband it carries along.
  typedef struct packed {
    logic               valid;
    logic [1:0]         status;
    logic               m12_neg;
    logic [60:0]        m12_mag;
    logic               diff_neg;
    logic [61:0]        diff_mag;
    logic signed [31:0] c;
    logic [61:0]        v;
    logic [32:0]        rem;
    logic [30:0]        root;
  } twf_root_t;

  // One lane of restoring division.
  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] num_lo;
    logic [31:0] quo;
    logic        ovf;
    logic [31:0] den;
  } twf_div_t;

  // Sideband beside the beta/alpha lanes; also holds the CORDIC vector.
  typedef struct packed {
    logic               valid;
    logic [1:0]         status;
    logic               beta_neg;
    logic               alpha_neg;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic [31:0]        cz;
  } twf_side_t;

  // Sideband beside the gamma lane.
  typedef struct packed {
    logic               valid;
    logic [1:0]         status;
    logic signed [31:0] beta;
    logic signed [31:0] alpha;
    logic [31:0]        tune;
    logic               gamma_neg;
  } twf_tail_t;

  // atan(2^-i) in turns, Q0.32
  function automatic logic [31:0] twf_atan(input logic [4:0] step);
    logic [31:0] r;
    case (step)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/twf_front.sv
`default_nettype none
module twf_front import twf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      take,
  input  twf_in_t   in_data,
  input  logic [23:0] scale,
  output twf_root_t q
);

  function automatic logic [49:0] diff_sm(input logic signed [47:0] a,
                                          input logic signed [47:0] b);
    logic signed [48:0] d;
    d = signed'({a[47], a}) - signed'({b[47], b});
    return {d[48], d[48] ? 49'(-d) : 49'(d)};
  endfunction

  logic        s1_valid, s2_valid, s3_valid, s4_valid;
  logic [48:0] s1_mag [3];
  logic        s1_neg [3];
  logic [48:0] s2_ph [3];
  logic [47:0] s2_pl [3];
  logic        s2_neg [3];
  logic signed [61:0] s3_m [3];
  logic [1:0]         s4_status;
  logic signed [31:0] s4_c;
  logic               s4_m12_neg;
  logic [60:0]        s4_m12_mag;
  logic               s4_diff_neg;
  logic [61:0]        s4_diff_mag;

  logic [49:0] sm [3];
  logic [60:0] p [3];
  logic signed [62:0] t, dm, tr;
  logic [31:0] cmag;
  logic [63:0] csq;

  always_comb begin
    sm[0] = diff_sm(in_data.pos_plus_x, in_data.pos_minus_x);
    sm[1] = diff_sm(in_data.pos_plus_xp, in_data.pos_minus_xp);
    sm[2] = diff_sm(in_data.ang_plus_xp, in_data.ang_minus_xp);
    for (int i = 0; i < 3; i++) begin
      p[i] = {s2_ph[i], 12'b0} + 61'(s2_pl[i][47:12]);
    end
    t  = 63'(s3_m[0]) + 63'(s3_m[2]);
    dm = 63'(s3_m[0]) - 63'(s3_m[2]);
    tr = t + (t < 0 ? 63'sd7 : 63'sd0);
    cmag = s4_c[31] ? 32'(-s4_c) : 32'(s4_c);
    csq  = cmag * cmag;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      q.valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      q.valid  <= s4_valid;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_neg[i] <= sm[i][49];
        s1_mag[i] <= sm[i][48:0];
        s2_ph[i]  <= s1_mag[i][48:24] * scale;
        s2_pl[i]  <= s1_mag[i][23:0] * scale;
        s2_neg[i] <= s1_neg[i];
        s3_m[i]   <= s2_neg[i] ? -signed'({1'b0, p[i]}) : signed'({1'b0, p[i]});
      end
      s4_status   <= (t > 63'sd8589934592 || t < -63'sd8589934592) ?
                     TWF_ST_UNSTABLE : TWF_ST_OK;
      s4_c        <= 32'(tr >>> 3);
      s4_m12_neg  <= s3_m[1] < 0;
      s4_m12_mag  <= 61'(s3_m[1] < 0 ? -s3_m[1] : s3_m[1]);
      s4_diff_neg <= dm < 0;
      s4_diff_mag <= 62'(dm < 0 ? -dm : dm);
      q.status    <= s4_status;
      q.m12_neg   <= s4_m12_neg;
      q.m12_mag   <= s4_m12_mag;
      q.diff_neg  <= s4_diff_neg;
      q.diff_mag  <= s4_diff_mag;
      q.c         <= s4_c;
      q.v         <= 62'(64'h1000_0000_0000_0000 - csq);
      q.rem       <= '0;
      q.root      <= '0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/twf_sqrt_cell.sv
`default_nettype none
module twf_sqrt_cell import twf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  twf_root_t d,
  output twf_root_t q
);

  logic [34:0] rem_sh, trial;
  twf_root_t   nxt;

  // one root bit: bring down two radicand bits, try 4*root+1
  always_comb begin
    rem_sh = {d.rem, d.v[61:60]};
    trial  = {2'b00, d.root, 2'b01};
    nxt    = d;
    nxt.v  = {d.v[59:0], 2'b00};
    if (rem_sh >= trial) begin
      nxt.rem  = 33'(rem_sh - trial);
      nxt.root = {d.root[29:0], 1'b1};
    end else begin
      nxt.rem  = rem_sh[32:0];
      nxt.root = {d.root[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/twf_div_cell.sv
`default_nettype none
module twf_div_cell import twf_pkg::*; (
  input  logic     clk,
  input  logic     adv,
  input  twf_div_t d,
  output twf_div_t q
);

  logic [33:0] rem_sh;
  twf_div_t    nxt;

  // one quotient bit: shift in the next numerator bit, subtract if it fits
  always_comb begin
    rem_sh     = {d.rem, d.num_lo[31]};
    nxt        = d;
    nxt.num_lo = {d.num_lo[30:0], 1'b0};
    if (rem_sh >= {2'b00, d.den}) begin
      nxt.rem = 33'(rem_sh - {2'b00, d.den});
      nxt.quo = {d.quo[30:0], 1'b1};
    end else begin
      nxt.rem = rem_sh[32:0];
      nxt.quo = {d.quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/twf_cordic_cell.sv
`default_nettype none
module twf_cordic_cell import twf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic [4:0] step,
  input  twf_side_t d,
  output twf_side_t q
);

  logic signed [33:0] dx, dy;
  logic [31:0]        ang;
  twf_side_t          nxt;

  // rotate toward y = 0; a vector already on the axis stays put
  always_comb begin
    dx  = d.cy >>> step;
    dy  = d.cx >>> step;
    ang = twf_atan(step);
    nxt = d;
    if (d.cy > 0) begin
      nxt.cx = d.cx + dx;
      nxt.cy = d.cy - dy;
      nxt.cz = d.cz + ang;
    end else if (d.cy < 0) begin
      nxt.cx = d.cx - dx;
      nxt.cy = d.cy + dy;
      nxt.cz = d.cz - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/twiss_from_one_turn_matrix.sv
// Twiss parameters (beta, alpha, gamma) and fractional tune from the final
// coordinates of four probe particles.
//
// Channels: in_valid/in_ready carry one probe set per transaction,
// out_valid/out_ready carry one result per transaction, in order.
// cfg_valid/cfg_ready writes half_inverse_offset; cfg_ready is always high.
// Write it only while no transaction is in flight.
//
// Throughput: one transaction per cycle while the output is not stalled.
// From input acceptance to out_valid the chain runs through 5 front stages
// (matrix, trace, cosine squared), 31 square-root cells, a setup stage and
// 32 division cells for beta/alpha with 30 CORDIC cells beside them,
// 3 gamma numerator stages, 32 more division cells and the output register.
//
// Stall: the whole chain advances together. When the output register holds
// a result that is not taken, every stage holds and in_ready drops.
// Reset (rst, synchronous) empties the chain and loads half_inverse_offset
// with 500000.
`default_nettype none
`include "twiss_from_one_turn_matrix_macros.svh"
module twiss_from_one_turn_matrix import twf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  twf_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output twf_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] half_inverse_offset
);

  // saturate a quotient magnitude and apply the sign
  function automatic logic signed [31:0] sat_quo(input logic [31:0] quo,
                                                  input logic ovf,
                                                  input logic neg);
    logic [31:0] lim, mag;
    lim = neg ? LimNeg : LimPos;
    mag = (ovf || quo > lim) ? lim : quo;
    return signed'(neg ? 32'(-mag) : mag);
  endfunction

  logic        adv;
  logic [23:0] scale;

  twf_root_t root_pipe [SqrtSteps+1];
  twf_side_t side_pipe [DivSteps+1];
  twf_div_t  beta_pipe [DivSteps+1];
  twf_div_t  alpha_pipe [DivSteps+1];
  twf_div_t  gamma_pipe [DivSteps+1];
  twf_tail_t tail_pipe [DivSteps+1];
  twf_tail_t t1, t2;
  logic [63:0] sq;

  // Advance everything unless a finished result is stuck at the output.
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= ScaleReset;
    end else if (cfg_valid) begin
      scale <= half_inverse_offset;
    end
  end

  // Front: difference quotients, trace, cosine and 1 - cos^2
  twf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .take    (in_valid),
    .in_data (in_data),
    .scale   (scale),
    .q       (root_pipe[0])
  );

  // Square-root chain: one root bit per cell gives the sine
  genvar k;
  generate
    for (k = 0; k < SqrtSteps; k++) begin : g_sqrt
      twf_sqrt_cell u_cell (
        .clk (clk),
        .rst (rst),
        .adv (adv),
        .d   (root_pipe[k]),
        .q   (root_pipe[k+1])
      );
    end
  endgenerate

  // Set up the beta and alpha divisions by the sine and the CORDIC vector.
  logic [74:0] nb, na;
  logic [30:0] s;
  twf_root_t   rr;

  always_comb begin
    rr = root_pipe[SqrtSteps];
    s  = rr.root;
    nb = {rr.m12_mag, 14'b0};
    na = {rr.diff_mag, 13'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_pipe[0].valid <= 1'b0;
    end else if (adv) begin
      side_pipe[0].valid <= rr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_pipe[0].status    <= (rr.status == TWF_ST_OK && s == '0) ?
                                TWF_ST_ZERO_DIV : rr.status;
      side_pipe[0].beta_neg  <= rr.m12_neg;
      side_pipe[0].alpha_neg <= rr.diff_neg;
      // bring a vector in the left half plane into the right one
      if (rr.c < 0) begin
        side_pipe[0].cx <= 34'(signed'({1'b0, s}));
        side_pipe[0].cy <= -(34'(rr.c));
        side_pipe[0].cz <= QuarterTurn;
      end else begin
        side_pipe[0].cx <= 34'(rr.c);
        side_pipe[0].cy <= 34'(signed'({1'b0, s}));
        side_pipe[0].cz <= '0;
      end
      beta_pipe[0].ovf     <= nb[74:32] >= {12'b0, s};
      beta_pipe[0].rem     <= nb[64:32];
      beta_pipe[0].num_lo  <= nb[31:0];
      beta_pipe[0].quo     <= '0;
      beta_pipe[0].den     <= {1'b0, s};
      alpha_pipe[0].ovf    <= na[74:32] >= {12'b0, s};
      alpha_pipe[0].rem    <= na[64:32];
      alpha_pipe[0].num_lo <= na[31:0];
      alpha_pipe[0].quo    <= '0;
      alpha_pipe[0].den    <= {1'b0, s};
    end
  end

  // Beta/alpha division lanes; CORDIC runs in the sideband beside them.
  generate
    for (k = 0; k < DivSteps; k++) begin : g_div1
      twf_div_cell u_beta (
        .clk (clk),
        .adv (adv),
        .d   (beta_pipe[k]),
        .q   (beta_pipe[k+1])
      );
      twf_div_cell u_alpha (
        .clk (clk),
        .adv (adv),
        .d   (alpha_pipe[k]),
        .q   (alpha_pipe[k+1])
      );
      if (k < CordicSteps) begin : g_rot
        twf_cordic_cell u_rot (
          .clk  (clk),
          .rst  (rst),
          .adv  (adv),
          .step (5'(k)),
          .d    (side_pipe[k]),
          .q    (side_pipe[k+1])
        );
      end else begin : g_hold
        always_ff @(posedge clk) begin
          if (rst) begin
            side_pipe[k+1].valid <= 1'b0;
          end else if (adv) begin
            side_pipe[k+1] <= side_pipe[k];
          end
        end
      end
    end
  endgenerate

  // Finish beta/alpha, fold the sign of m12 into the tune.
  twf_side_t          se;
  logic signed [31:0] beta_v, alpha_v;
  logic [31:0]        amag;

  always_comb begin
    se      = side_pipe[DivSteps];
    beta_v  = sat_quo(beta_pipe[DivSteps].quo, beta_pipe[DivSteps].ovf, se.beta_neg);
    alpha_v = sat_quo(alpha_pipe[DivSteps].quo, alpha_pipe[DivSteps].ovf, se.alpha_neg);
    amag    = t1.alpha[31] ? 32'(-t1.alpha) : 32'(t1.alpha);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
      t2.valid <= 1'b0;
    end else if (adv) begin
      t1.valid <= se.valid;
      t2.valid <= t1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1.status    <= (se.status == TWF_ST_OK && beta_v == 0) ? TWF_ST_ZERO_DIV : se.status;
      t1.beta      <= beta_v;
      t1.alpha     <= alpha_v;
      t1.tune      <= se.beta_neg ? 32'(-se.cz) : se.cz;
      t1.gamma_neg <= beta_v < 0;
      t2.status    <= t1.status;
      t2.beta      <= t1.beta;
      t2.alpha     <= t1.alpha;
      t2.tune      <= t1.tune;
      t2.gamma_neg <= t1.gamma_neg;
      // square alpha for gamma's numerator
      sq <= amag * amag;
    end
  end

  // Gamma numerator 1 + alpha^2 over |beta|
  logic [63:0] ng;
  logic [31:0] bmag;

  always_comb begin
    ng   = sq + 64'h1_0000_0000;
    bmag = t2.beta[31] ? 32'(-t2.beta) : 32'(t2.beta);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_pipe[0].valid <= 1'b0;
    end else if (adv) begin
      tail_pipe[0].valid <= t2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tail_pipe[0].status    <= t2.status;
      tail_pipe[0].beta      <= t2.beta;
      tail_pipe[0].alpha     <= t2.alpha;
      tail_pipe[0].tune      <= t2.tune;
      tail_pipe[0].gamma_neg <= t2.gamma_neg;
      gamma_pipe[0].ovf      <= ng[63:32] >= bmag;
      gamma_pipe[0].rem      <= {1'b0, ng[63:32]};
      gamma_pipe[0].num_lo   <= ng[31:0];
      gamma_pipe[0].quo      <= '0;
      gamma_pipe[0].den      <= bmag;
    end
  end

  generate
    for (k = 0; k < DivSteps; k++) begin : g_div2
      twf_div_cell u_gamma (
        .clk (clk),
        .adv (adv),
        .d   (gamma_pipe[k]),
        .q   (gamma_pipe[k+1])
      );
      always_ff @(posedge clk) begin
        if (rst) begin
          tail_pipe[k+1].valid <= 1'b0;
        end else if (adv) begin
          tail_pipe[k+1] <= tail_pipe[k];
        end
      end
    end
  endgenerate

  // Output register: zero every value field when a fault is flagged.
  twf_tail_t te;
  logic      fault;

  always_comb begin
    te    = tail_pipe[DivSteps];
    fault = te.status != TWF_ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= te.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.status        <= te.status;
      out_data.beta_value    <= fault ? '0 : te.beta;
      out_data.alpha_value   <= fault ? '0 : te.alpha;
      out_data.gamma_value   <= fault ? '0 :
                                sat_quo(gamma_pipe[DivSteps].quo, gamma_pipe[DivSteps].ovf,
                                        te.gamma_neg);
      out_data.tune_fraction <= fault ? '0 : te.tune;
    end
  end

  `TWF_ASSERT_NOW(a_status_code, out_valid, out_data.status == TWF_ST_OK || out_data.status == TWF_ST_UNSTABLE || out_data.status == TWF_ST_ZERO_DIV)
  `TWF_ASSERT_NOW(a_fault_clears, out_valid && out_data.status != TWF_ST_OK, out_data.beta_value == 0 && out_data.alpha_value == 0 && out_data.gamma_value == 0 && out_data.tune_fraction == 0)
  `TWF_ASSERT_NOW(a_beta_nonzero, out_valid && out_data.status == TWF_ST_OK, out_data.beta_value != 0)
  `TWF_ASSERT_NOW(a_stall_blocks_input, out_valid && !out_ready, !in_ready)

endmodule
`default_nettype wire
